// File: src/sgb_pkg.sv
// Shared types and constants for the separable Gaussian blur unit.
// No dependencies; imported by every module of the block.
package sgb_pkg;

   localparam int MAX_PIXELS_STORED = 65536;
   localparam int MAX_RADIUS        = 16;
   localparam int ADDR_W            = 16;
   localparam int DIM_W             = 9;
   localparam int COORD_W           = 8;
   localparam int RAD_W             = 5;
   localparam int TAP_W             = 6;
   localparam int WT_W              = 16;
   localparam int PX_W              = 24;
   localparam int PROD_W            = 24;
   localparam int ACC_W             = 30;
   localparam int NSUM_W            = 22;
   localparam int CNT_W             = 3;
   localparam int CSR_IDX_W         = 2;
   localparam int NPIX_W            = 17;

   localparam logic [1:0] CMD_LOAD_WEIGHT = 2'd0;
   localparam logic [1:0] CMD_WRITE_PIXEL = 2'd1;
   localparam logic [1:0] CMD_RUN_FILTER  = 2'd2;
   localparam logic [1:0] CMD_READ_PIXEL  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUR_RADIUS  = 2'd2;

   typedef struct packed {
      logic                     host_wr_px;
      logic                     host_wr_wt;
      logic                     host_rd;
      logic [ADDR_W-1:0]        host_addr;
      logic [PX_W-1:0]          host_px;
      logic [WT_W-1:0]          host_wt;
      logic                     tap_issue;
      logic                     pass;       // 0 horizontal, 1 vertical
      logic [COORD_W-1:0]       x;
      logic [COORD_W-1:0]       y;
      logic signed [TAP_W-1:0]  tap;
      logic                     acc_clear;
      logic                     div_step;
      logic                     div_first;
      logic [CNT_W-1:0]         div_bit;
      logic                     px_write;
      logic [DIM_W-1:0]         w_eff;
      logic [DIM_W-1:0]         h_eff;
   } sgb_cmd_type;

   typedef struct packed {
      logic [PX_W-1:0] rd_pixel;
   } sgb_status_type;

endpackage

// File: src/sgb_datapath.sv
// Datapath: image and scratch stores, weight table, tap MAC pipeline, divider.
// Depends on sgb_pkg; driven by sgb_ctrl through sgb_cmd_type.
module sgb_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  sgb_pkg::sgb_cmd_type   cmd,
   output sgb_pkg::sgb_status_type status
);
   import sgb_pkg::*;

   logic [PX_W-1:0] image_store_ff   [MAX_PIXELS_STORED];
   logic [PX_W-1:0] scratch_store_ff [MAX_PIXELS_STORED];
   logic [WT_W-1:0] weight_ff [MAX_RADIUS+1];

   logic [PX_W-1:0]    image_q_ff, scratch_q_ff;
   logic               vld0_ff, vld1_ff, src0_ff;
   logic [WT_W-1:0]    wt0_ff, wt1_ff;
   logic [PROD_W-1:0]  prod_ff [3];
   logic [ACC_W-1:0]   acc_ff [3];
   logic [ACC_W-1:0]   rem_ff [3];
   logic [ACC_W-1:0]   rem_in [3];
   logic [7:0]         q_ff [3];
   logic [7:0]         q_in [3];
   logic [NSUM_W-1:0]  nsum_ff;

   logic [COORD_W-1:0]      pos;
   logic signed [DIM_W:0]   p_s;
   logic [DIM_W-1:0]        lim;
   logic                    in_range;
   logic [COORD_W-1:0]      mul_a, add_b;
   logic [NPIX_W-1:0]       row_base;
   logic [ADDR_W-1:0]       pix_addr, rd_addr;
   logic [RAD_W-1:0]        wt_idx;
   logic [PX_W-1:0]         src_px, wr_px;
   logic [ACC_W:0]          divisor;
   logic [ACC_W-1:0]        rem_src;
   logic                    ge;
   integer                  c;

   always_comb begin
      pos      = cmd.pass ? cmd.y : cmd.x;
      p_s      = $signed({2'b00, pos}) + {{(DIM_W+1-TAP_W){cmd.tap[TAP_W-1]}}, cmd.tap};
      lim      = cmd.pass ? cmd.h_eff : cmd.w_eff;
      in_range = !p_s[DIM_W] && (p_s[DIM_W-1:0] < lim);
      mul_a    = (cmd.px_write || !cmd.pass) ? cmd.y : p_s[COORD_W-1:0];
      add_b    = (cmd.px_write ||  cmd.pass) ? cmd.x : p_s[COORD_W-1:0];
      row_base = mul_a * cmd.w_eff;
      pix_addr = row_base[ADDR_W-1:0] + {{(ADDR_W-COORD_W){1'b0}}, add_b};
      rd_addr  = cmd.host_rd ? cmd.host_addr : pix_addr;
      wt_idx   = cmd.tap[TAP_W-1] ? RAD_W'(-cmd.tap) : cmd.tap[RAD_W-1:0];
      src_px   = src0_ff ? scratch_q_ff : image_q_ff;
      wr_px    = (nsum_ff == '0) ? '0 : {q_ff[0], q_ff[1], q_ff[2]};
      divisor  = {{(ACC_W+1-NSUM_W){1'b0}}, nsum_ff} << cmd.div_bit;
   end

   // Restoring division, one quotient bit per step for each color.
   always_comb begin
      for (c = 0; c < 3; c = c + 1) begin
         rem_src  = cmd.div_first ? acc_ff[c] : rem_ff[c];
         ge       = {1'b0, rem_src} >= divisor;
         rem_in[c] = ge ? ACC_W'({1'b0, rem_src} - divisor) : rem_src;
         q_in[c]  = {q_ff[c][6:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.host_wr_px) begin
         image_store_ff[cmd.host_addr] <= cmd.host_px;
      end else if (cmd.px_write && cmd.pass) begin
         image_store_ff[pix_addr] <= wr_px;
      end
      if (cmd.px_write && !cmd.pass) begin
         scratch_store_ff[pix_addr] <= wr_px;
      end
      image_q_ff   <= image_store_ff[rd_addr];
      scratch_q_ff <= scratch_store_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= MAX_RADIUS; i++) weight_ff[i] <= '0;
      end else if (cmd.host_wr_wt) begin
         weight_ff[cmd.host_addr[RAD_W-1:0]] <= cmd.host_wt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
         vld1_ff <= 1'b0;
      end else begin
         vld0_ff <= cmd.tap_issue && in_range;
         vld1_ff <= vld0_ff;
      end
   end

   always_ff @(posedge clock) begin
      wt0_ff     <= weight_ff[wt_idx];
      src0_ff    <= cmd.pass;
      wt1_ff     <= wt0_ff;
      prod_ff[0] <= wt0_ff * src_px[23:16];
      prod_ff[1] <= wt0_ff * src_px[15:8];
      prod_ff[2] <= wt0_ff * src_px[7:0];
      if (cmd.acc_clear) begin
         nsum_ff <= '0;
      end else if (vld1_ff) begin
         nsum_ff <= nsum_ff + NSUM_W'(wt1_ff);
      end
      for (int k = 0; k < 3; k++) begin
         if (cmd.acc_clear) begin
            acc_ff[k] <= '0;
         end else if (vld1_ff) begin
            acc_ff[k] <= acc_ff[k] + ACC_W'(prod_ff[k]);
         end
         if (cmd.div_step) begin
            rem_ff[k] <= rem_in[k];
            q_ff[k]   <= q_in[k];
         end
      end
   end

   assign status.rd_pixel = image_q_ff;

endmodule

// File: src/sgb_ctrl.sv
// Controller: configuration registers, command decode, pass sequencer, result register.
// Depends on sgb_pkg; commands sgb_datapath through sgb_cmd_type.
module sgb_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [sgb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sgb_pkg::DIM_W-1:0] csr_data,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [55:0]               req_tdata,
   input  logic [1:0]                req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [23:0]               rsp_tdata,
   output logic                      rsp_tuser,
   output sgb_pkg::sgb_cmd_type      cmd,
   input  sgb_pkg::sgb_status_type   status
);
   import sgb_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_TAPS  = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_WRITE = 3'd5;
   localparam logic [2:0] S_RESP  = 3'd6;

   logic [2:0]              state_ff, state_in;
   logic [DIM_W-1:0]        width_ff, height_ff;
   logic [RAD_W-1:0]        radius_ff;
   logic [COORD_W-1:0]      x_ff, x_in, y_ff, y_in;
   logic                    pass_ff, pass_in;
   logic signed [TAP_W-1:0] tap_ff, tap_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [23:0]             rsp_data_ff, rsp_data_in;
   logic                    rsp_err_ff, rsp_err_in;

   logic [DIM_W-1:0]        w_eff, h_eff;
   logic [RAD_W-1:0]        r_eff;
   logic signed [TAP_W-1:0] tap_first, tap_last;
   logic [NPIX_W-1:0]       npix;
   logic                    accept, out_free, addr_bad_px, addr_bad_wt;
   logic                    x_last, y_last;
   logic [1:0]              req_cmd;
   logic [ADDR_W-1:0]       req_addr;

   always_comb begin
      w_eff     = (width_ff == '0) ? DIM_W'(1) :
                  (width_ff > DIM_W'(256)) ? DIM_W'(256) : width_ff;
      h_eff     = (height_ff == '0) ? DIM_W'(1) :
                  (height_ff > DIM_W'(256)) ? DIM_W'(256) : height_ff;
      r_eff     = (radius_ff > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_ff;
      tap_last  = $signed({1'b0, r_eff});
      tap_first = -tap_last;
      npix      = w_eff * h_eff;
      req_cmd   = req_tuser;
      req_addr  = req_tdata[15:0];
      out_free  = !rsp_valid_ff || rsp_tready;
      req_tready = (state_ff == S_IDLE) && out_free;
      accept    = req_tvalid && req_tready;
      addr_bad_px = {1'b0, req_addr} >= npix;
      addr_bad_wt = req_addr > ADDR_W'(MAX_RADIUS);
      x_last    = {1'b0, x_ff} == (w_eff - DIM_W'(1));
      y_last    = {1'b0, y_ff} == (h_eff - DIM_W'(1));
   end

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      pass_in      = pass_ff;
      tap_in       = tap_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;

      cmd            = '0;
      cmd.host_addr  = req_addr;
      cmd.host_px    = {req_tdata[23:16], req_tdata[31:24], req_tdata[39:32]};
      cmd.host_wt    = req_tdata[55:40];
      cmd.pass       = pass_ff;
      cmd.x          = x_ff;
      cmd.y          = y_ff;
      cmd.tap        = tap_ff;
      cmd.div_bit    = CNT_W'(7) - cnt_ff;
      cmd.w_eff      = w_eff;
      cmd.h_eff      = h_eff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  CMD_LOAD_WEIGHT: begin
                     cmd.host_wr_wt = !addr_bad_wt;
                     rsp_valid_in   = 1'b1;
                     rsp_data_in    = '0;
                     rsp_err_in     = addr_bad_wt;
                  end
                  CMD_WRITE_PIXEL: begin
                     cmd.host_wr_px = !addr_bad_px;
                     rsp_valid_in   = 1'b1;
                     rsp_data_in    = '0;
                     rsp_err_in     = addr_bad_px;
                  end
                  CMD_RUN_FILTER: begin
                     cmd.acc_clear = 1'b1;
                     x_in     = '0;
                     y_in     = '0;
                     pass_in  = 1'b0;
                     tap_in   = tap_first;
                     state_in = S_TAPS;
                  end
                  default: begin
                     if (addr_bad_px) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '0;
                        rsp_err_in   = 1'b1;
                     end else begin
                        cmd.host_rd = 1'b1;
                        state_in    = S_READ;
                     end
                  end
               endcase
            end
         end
         S_READ: begin
            // result register was freed at the accepting edge; red goes to the low byte
            rsp_valid_in = 1'b1;
            rsp_data_in  = {status.rd_pixel[7:0], status.rd_pixel[15:8],
                            status.rd_pixel[23:16]};
            rsp_err_in   = 1'b0;
            state_in     = S_IDLE;
         end
         S_TAPS: begin
            cmd.tap_issue = 1'b1;
            if (tap_ff == tap_last) begin
               cnt_in   = '0;
               state_in = S_DRAIN;
            end else begin
               tap_in = tap_ff + TAP_W'(1);
            end
         end
         S_DRAIN: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step  = 1'b1;
            cmd.div_first = (cnt_ff == '0);
            cnt_in        = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(7)) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.px_write  = 1'b1;
            cmd.acc_clear = 1'b1;
            tap_in        = tap_first;
            state_in      = S_TAPS;
            if (!x_last) begin
               x_in = x_ff + COORD_W'(1);
            end else begin
               x_in = '0;
               if (!y_last) begin
                  y_in = y_ff + COORD_W'(1);
               end else begin
                  y_in    = '0;
                  pass_in = 1'b1;
                  if (pass_ff) begin
                     state_in = S_RESP;
                  end
               end
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_err_in   = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         width_ff     <= DIM_W'(256);
         height_ff    <= DIM_W'(256);
         radius_ff    <= RAD_W'(1);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_IMAGE_WIDTH:  width_ff  <= csr_data;
               CSR_IMAGE_HEIGHT: height_ff <= csr_data;
               CSR_BLUR_RADIUS:  radius_ff <= csr_data[RAD_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      pass_ff     <= pass_in;
      tap_ff      <= tap_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule

// File: src/separable_gaussian_blur_unit.sv
// Top level of the separable Gaussian blur unit.
// Depends on sgb_pkg, sgb_ctrl and sgb_datapath.
//
// Send commands on req_: load weight, write pixel, run filter, read pixel;
// every accepted command returns exactly one transfer on rsp_. Weight loads,
// pixel writes and rejected reads answer on the next cycle and can follow
// one per cycle while rsp_ keeps draining. A valid read answers after the
// registered store read and the S_READ state. A run walks each pass pixel
// by pixel through one multiply-accumulate lane: it issues taps -r to r,
// with r the clamped radius, drains the pipeline, runs the divider (one
// quotient bit per cycle) and writes the pixel; the run then returns its
// result. The stores power up undefined: write every pixel of the
// configured image before running or reading.
// Write the csr_ registers only while the block is idle.
module separable_gaussian_blur_unit (
   input  logic        clock,
   input  logic        reset,
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_data,
   // commands
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // address, in_red, in_green, in_blue, weight_value
   input  logic [1:0]  req_tuser,  // cmd
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // out_red, out_green, out_blue
   output logic        rsp_tuser   // error
);
   import sgb_pkg::*;

   sgb_cmd_type    cmd;
   sgb_status_type status;

   // sequencing, configuration and result register
   sgb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .status     (status)
   );

   // stores, weights and arithmetic
   sgb_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (status)
   );

endmodule

// File: src/sgb_checker.sv
// Port-level checks for the separable Gaussian blur unit.
// Depends on separable_gaussian_blur_unit; attached by the bind below.
module sgb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [55:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser
);
   import sgb_pkg::*;

   logic req_xfer;
   assign req_xfer = req_tvalid && req_tready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_tuser == CMD_RUN_FILTER |=> !req_tready)
      else $error("command taken during a run");

   a_bad_weight: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_tuser == CMD_LOAD_WEIGHT && req_tdata[15:0] > 16'd16
      |=> rsp_tvalid && rsp_tuser)
      else $error("bad weight index not flagged");

   a_load_zero: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_tuser == CMD_LOAD_WEIGHT |=> rsp_tvalid && rsp_tdata == 24'd0)
      else $error("weight load returned data");

endmodule

bind separable_gaussian_blur_unit sgb_checker u_sgb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: tb/sv/testbench.sv
// Self-checking testbench for separable_gaussian_blur_unit: scoreboard class that
// predicts every response, plus tasks that drive commands and csr writes.
// Depends on sgb_pkg and the RTL of the blur unit.
`timescale 1ns / 100ps

import sgb_pkg::*;

typedef struct {
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       error;
} blur_answer_type;

class blur_scoreboard;
   logic [23:0]  image_px [MAX_PIXELS_STORED];
   logic [23:0]  scratch_px [MAX_PIXELS_STORED];
   bit           written [MAX_PIXELS_STORED];
   logic [15:0]  weights [MAX_RADIUS+1];
   logic [8:0]   width_reg;
   logic [8:0]   height_reg;
   logic [4:0]   radius_reg;
   blur_answer_type answers [$];
   int           mismatches;
   int           checked;

   function new();
      for (int i = 0; i <= MAX_RADIUS; i++) weights[i] = '0;
      width_reg  = 9'd256;
      height_reg = 9'd256;
      radius_reg = 5'd1;
      mismatches = 0;
      checked    = 0;
   endfunction

   function int eff_w();
      int w;
      w = width_reg;
      if (w < 1) w = 1;
      if (w > 256) w = 256;
      return w;
   endfunction

   function int eff_h();
      int h;
      h = height_reg;
      if (h < 1) h = 1;
      if (h > 256) h = 256;
      if (eff_w() * h > MAX_PIXELS_STORED) h = MAX_PIXELS_STORED / eff_w();
      return h;
   endfunction

   function void set_reg(logic [1:0] idx, logic [8:0] value);
      if (idx == CSR_IMAGE_WIDTH) width_reg = value;
      else if (idx == CSR_IMAGE_HEIGHT) height_reg = value;
      else if (idx == CSR_BLUR_RADIUS) radius_reg = value[4:0];
   endfunction

   // One output pixel of a pass; horiz reads the image store, else the scratch store.
   function logic [23:0] filter_px(bit horiz, int x, int y, int w, int h, int rad);
      longint acc [3];
      longint n, wt;
      int pos, lim, idx;
      logic [23:0] px, res;
      acc[0] = 0; acc[1] = 0; acc[2] = 0;
      n = weights[0];
      pos = horiz ? x : y;
      lim = horiz ? w : h;
      px = horiz ? image_px[y*w+x] : scratch_px[y*w+x];
      for (int c = 0; c < 3; c++) acc[c] += n * px[23-8*c -: 8];
      for (int k = 1; k <= rad; k++) begin
         wt = weights[k];
         for (int s = -1; s <= 1; s += 2) begin
            if (pos + s*k >= 0 && pos + s*k < lim) begin
               idx = horiz ? (y*w + x + s*k) : ((y + s*k)*w + x);
               px = horiz ? image_px[idx] : scratch_px[idx];
               for (int c = 0; c < 3; c++) acc[c] += wt * px[23-8*c -: 8];
               n += wt;
            end
         end
      end
      for (int c = 0; c < 3; c++) begin
         acc[c] = (n != 0) ? acc[c] / n : 0;
         if (acc[c] > 255) acc[c] = 255;
         res[23-8*c -: 8] = acc[c][7:0];
      end
      return res;
   endfunction

   function void run_blur();
      int w, h, rad;
      w = eff_w();
      h = eff_h();
      rad = (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
      for (int y = 0; y < h; y++)
         for (int x = 0; x < w; x++) scratch_px[y*w+x] = filter_px(1, x, y, w, h, rad);
      for (int y = 0; y < h; y++)
         for (int x = 0; x < w; x++) image_px[y*w+x] = filter_px(0, x, y, w, h, rad);
   endfunction

   // Note an accepted command and queue the response it must produce.
   function void note_command(logic [1:0] cmd, logic [15:0] addr, logic [23:0] px,
                              logic [15:0] wt);
      blur_answer_type a;
      int npix;
      npix = eff_w() * eff_h();
      a.red = 8'd0; a.green = 8'd0; a.blue = 8'd0; a.error = 1'b0;
      case (cmd)
         CMD_LOAD_WEIGHT: begin
            if (addr <= MAX_RADIUS) weights[addr] = wt;
            else a.error = 1'b1;
         end
         CMD_WRITE_PIXEL: begin
            if (addr < npix) begin
               image_px[addr] = px;
               written[addr] = 1'b1;
            end else a.error = 1'b1;
         end
         CMD_RUN_FILTER: run_blur();
         default: begin
            if (addr < npix) begin
               a.red = image_px[addr][23:16];
               a.green = image_px[addr][15:8];
               a.blue = image_px[addr][7:0];
            end else a.error = 1'b1;
         end
      endcase
      answers.push_back(a);
   endfunction

   function void check_response(logic [23:0] data, logic err);
      blur_answer_type a;
      if (answers.size() == 0) begin
         $display("%0t: response with nothing expected: data %h error %b", $time, data, err);
         mismatches++;
         return;
      end
      a = answers.pop_front();
      checked++;
      if (data[7:0] !== a.red) begin
         $display("%0t: red expected %h actual %h", $time, a.red, data[7:0]);
         mismatches++;
      end
      if (data[15:8] !== a.green) begin
         $display("%0t: green expected %h actual %h", $time, a.green, data[15:8]);
         mismatches++;
      end
      if (data[23:16] !== a.blue) begin
         $display("%0t: blue expected %h actual %h", $time, a.blue, data[23:16]);
         mismatches++;
      end
      if (err !== a.error) begin
         $display("%0t: error expected %b actual %b", $time, a.error, err);
         mismatches++;
      end
   endfunction
endclass

module testbench;
   logic        clock = 0;
   logic        reset = 1;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [8:0]  csr_data = '0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;

   blur_scoreboard sb = new();
   logic [15:0] written_addrs [$];
   int          commands_sent = 0;
   int          runs_sent = 0;
   int          phases_done = 0;

   separable_gaussian_blur_unit dut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // Watchdog: end the run if no transfer happens for a long stretch.
   int quiet = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet > 200000) begin
         $display("watchdog expired after %0d idle cycles", quiet);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Response side: random stalls before each response, plus one long hold-off
   // so the block backs up and stalls its command input.
   initial begin : response_sink
      int gap;
      bit held;
      held = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = $urandom_range(0, 3);
         if (!held && sb.checked == 300) begin
            gap = 200;
            held = 1;
         end
         rsp_tready = 0;
         repeat (gap) @(negedge clock);
         rsp_tready = 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         sb.check_response(rsp_tdata, rsp_tuser);
         @(negedge clock);
      end
   end

   // Drive one command; called at a falling edge, returns at a falling edge
   // with valid still high so back-to-back transfers need no dip.
   task automatic send_cmd(logic [1:0] cmd, logic [15:0] addr, logic [23:0] px,
                           logic [15:0] wt);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid = 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1;
      req_tuser = cmd;
      req_tdata = {wt, px[7:0], px[15:8], px[23:16], addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_command(cmd, addr, px, wt);
      commands_sent++;
      if (cmd == CMD_RUN_FILTER) runs_sent++;
      if (cmd == CMD_WRITE_PIXEL && addr < sb.eff_w() * sb.eff_h()) written_addrs.push_back(addr);
      @(negedge clock);
   endtask

   // Hold off until every expected response is back, then settle.
   task automatic drain();
      req_tvalid = 0;
      while (sb.answers.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [8:0] value);
      csr_valid = 1;
      csr_index = idx;
      csr_data = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(idx, value);
      @(negedge clock);
      csr_valid = 0;
   endtask

   // Reconfigure while idle and, when fill is set, fill the whole image so runs and reads stay defined.
   task automatic start_phase(logic [8:0] w, logic [8:0] h, logic [4:0] r, bit fill);
      drain();
      write_csr(CSR_IMAGE_WIDTH, w);
      write_csr(CSR_IMAGE_HEIGHT, h);
      write_csr(CSR_BLUR_RADIUS, r);
      written_addrs.delete();
      if (fill)
         for (int i = 0; i < sb.eff_w() * sb.eff_h(); i++)
            send_cmd(CMD_WRITE_PIXEL, i[15:0], 24'($urandom()), 16'd0);
      phases_done++;
   endtask

   task automatic load_weights(bit zero);
      for (int k = 0; k <= MAX_RADIUS; k++)
         send_cmd(CMD_LOAD_WEIGHT, k[15:0], 24'($urandom()),
                  zero ? 16'd0 : 16'($urandom()));
   endtask

   // Mixed traffic; reads only hit written entries or land out of range.
   task automatic random_mix(int count, bit allow_run);
      int sel, npix;
      logic [15:0] addr;
      npix = sb.eff_w() * sb.eff_h();
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 35) begin
            addr = ($urandom_range(0, 9) == 0 || npix >= 65536) ? 16'($urandom())
                                                               : 16'($urandom_range(0, npix-1));
            send_cmd(CMD_WRITE_PIXEL, addr, 24'($urandom()), 16'($urandom()));
         end else if (sel < 72) begin
            if ($urandom_range(0, 9) == 0 && npix < 65536)
               addr = 16'($urandom_range(npix, 65535));
            else if (written_addrs.size() == 0)
               addr = 16'hFFFF;
            else
               addr = written_addrs[$urandom_range(0, written_addrs.size()-1)];
            if (npix >= 65536 && written_addrs.size() == 0) continue;
            send_cmd(CMD_READ_PIXEL, addr, 24'($urandom()), 16'($urandom()));
         end else if (sel < 95 || !allow_run) begin
            addr = ($urandom_range(0, 4) == 0) ? 16'($urandom())
                                               : 16'($urandom_range(0, MAX_RADIUS));
            send_cmd(CMD_LOAD_WEIGHT, addr, 24'($urandom()), 16'($urandom()));
         end else begin
            send_cmd(CMD_RUN_FILTER, 16'($urandom()), 24'($urandom()), 16'($urandom()));
         end
      end
   endtask

   initial begin : stimulus
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: small image, weight index extremes, pixel index extremes.
      start_phase(9'd4, 9'd4, 5'd1, 1);
      load_weights(0);
      send_cmd(CMD_LOAD_WEIGHT, 16'd17, 24'h0, 16'hFFFF);
      send_cmd(CMD_LOAD_WEIGHT, 16'hFFFF, 24'hFFFFFF, 16'h0);
      send_cmd(CMD_WRITE_PIXEL, 16'd0, 24'hFFFFFF, 16'hFFFF);
      send_cmd(CMD_WRITE_PIXEL, 16'd15, 24'h000000, 16'h0);
      send_cmd(CMD_WRITE_PIXEL, 16'd16, 24'h123456, 16'h0);
      send_cmd(CMD_READ_PIXEL, 16'd16, 24'h0, 16'h0);
      send_cmd(CMD_READ_PIXEL, 16'hFFFF, 24'h0, 16'h0);
      send_cmd(CMD_READ_PIXEL, 16'd0, 24'h0, 16'h0);
      send_cmd(CMD_RUN_FILTER, 16'hFFFF, 24'hFFFFFF, 16'hFFFF);
      send_cmd(CMD_READ_PIXEL, 16'd0, 24'h0, 16'h0);
      send_cmd(CMD_READ_PIXEL, 16'd15, 24'h0, 16'h0);

      // One wide row, widest radius; the long response hold-off falls here.
      start_phase(9'd256, 9'd1, 5'd16, 1);
      load_weights(0);
      random_mix(40, 1);

      // One tall column.
      start_phase(9'd1, 9'd256, 5'd16, 1);
      random_mix(40, 1);

      // Zero size acts as one pixel, zero radius means the center tap only.
      start_phase(9'd0, 9'd0, 5'd0, 1);
      random_mix(20, 1);

      // Oversized registers clamp to the full store; no run, reads only of writes.
      start_phase(9'd511, 9'd511, 5'd31, 0);
      random_mix(100, 0);

      // All weights zero: every filtered pixel becomes zero.
      start_phase(9'd3, 9'd3, 5'd2, 1);
      load_weights(1);
      send_cmd(CMD_RUN_FILTER, 16'd0, 24'h0, 16'h0);
      for (int i = 0; i < 9; i++) send_cmd(CMD_READ_PIXEL, i[15:0], 24'h0, 16'h0);

      start_phase(9'd7, 9'd5, 5'd31, 1);
      load_weights(0);
      random_mix(150, 1);

      start_phase(9'd16, 9'd16, 5'd5, 1);
      random_mix(100, 1);

      start_phase(9'd8, 9'd6, 5'd3, 1);
      load_weights(0);
      random_mix(130, 1);

      drain();
      repeat (20) @(negedge clock);
      $display("covered %0d commands (%0d filter runs) over %0d register settings",
               commands_sent, runs_sent, phases_done);
      $display("%0d responses checked, %0d mismatches", sb.checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.answers.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
